/* hdl/seau_pkg.sv */
// package of shared types and constants for the syscall energy attribution unit
package seau_pkg;

    localparam int unsigned SYSCALL_BINS_DEF = 512;
    localparam int unsigned THREAD_SLOTS_DEF = 64;

    localparam logic [2:0] OP_ENTER  = 3'd0;
    localparam logic [2:0] OP_EXIT   = 3'd1;
    localparam logic [2:0] OP_SW_OUT = 3'd2;
    localparam logic [2:0] OP_SW_IN  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] thread_id;
        logic [15:0] syscall_number;
        logic [31:0] energy_reading;
    } t_event;

    typedef struct packed {
        logic [63:0] bin_energy;
        logic [31:0] bin_calls;
        logic        event_dropped;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_BIN_RD,
        ST_BIN_WAIT,
        ST_BIN_WR,
        ST_CLEAR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic bin_rd;
        logic bin_wr;
        logic clr_start;
        logic clr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic need_bin;
        logic is_clear;
        logic clr_done;
    } t_status;

endpackage

/* hdl/seau_if.sv */
// valid/ready channel interface
interface seau_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/seau_ctrl.sv */
// controller state machine for the syscall energy attribution unit
module seau_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  seau_pkg::t_status i_status,
    output seau_pkg::t_cmd    o_cmd
);
    import seau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.is_clear) begin
                    n_state = ST_CLEAR;
                end else if (i_status.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = i_status.need_bin ? ST_BIN_RD : ST_OUT;
            end
            ST_BIN_RD:   n_state = ST_BIN_WAIT;
            ST_BIN_WAIT: n_state = ST_BIN_WR;
            ST_BIN_WR:   n_state = ST_OUT;
            ST_CLEAR: begin
                if (i_status.clr_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load       = i_in_valid;
                o_cmd.scan_start = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.clr_start = i_status.is_clear;
            end
            ST_DECIDE:   o_cmd.decide = 1'b1;
            ST_BIN_RD:   o_cmd.bin_rd = 1'b1;
            ST_BIN_WAIT: o_cmd.out_load = 1'b1;
            ST_BIN_WR:   o_cmd.bin_wr = 1'b1;
            ST_CLEAR:    o_cmd.clr_step = 1'b1;
            ST_OUT:      o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

/* hdl/seau_dp.sv */
// datapath with thread table, bin memories and bin arithmetic
module seau_dp #(
    parameter int unsigned SYSCALL_BINS = seau_pkg::SYSCALL_BINS_DEF,
    parameter int unsigned THREAD_SLOTS = seau_pkg::THREAD_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  seau_pkg::t_event   i_event,
    input  seau_pkg::t_cmd     i_cmd,
    output seau_pkg::t_status  o_status,
    output seau_pkg::t_result  o_result
);
    import seau_pkg::*;

    localparam int unsigned SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int unsigned BW = (SYSCALL_BINS > 1) ? $clog2(SYSCALL_BINS) : 1;
    localparam int unsigned CW = $clog2(SYSCALL_BINS + 1);
    localparam int unsigned TW = $clog2(THREAD_SLOTS + 1);

    // thread table
    logic [THREAD_SLOTS-1:0] r_valid, r_in_call, r_running;
    logic [31:0]             r_thread [THREAD_SLOTS];
    logic [BW-1:0]           r_sysc   [THREAD_SLOTS];
    logic [31:0]             r_start  [THREAD_SLOTS];

    // bin memories with epoch-free valid sweep via clearing pass
    logic [63:0] r_ebin [SYSCALL_BINS];
    logic [31:0] r_cbin [SYSCALL_BINS];

    t_event      r_ev;
    logic [TW-1:0] r_scan;
    logic        r_hit, r_free_found;
    logic [SW-1:0] r_hit_idx, r_free_idx;
    logic        r_add_e, r_add_c, r_is_read;
    logic [BW-1:0] r_bin;
    logic [31:0] r_delta;
    logic [63:0] r_rd_e;
    logic [31:0] r_rd_c;
    logic [CW-1:0] r_clr;
    logic        r_clr_busy;
    t_result     r_res;

    // registered table read during the scan
    logic          r_pv;
    logic [SW-1:0] r_p_idx;
    logic          r_p_vld;
    logic [31:0]   r_p_thr;
    logic [BW-1:0] r_p_sysc;
    logic [31:0]   r_p_start;
    logic [BW-1:0] r_hit_sysc;
    logic [31:0]   r_hit_start;

    logic          n_need_bin, n_add_e, n_add_c, n_is_read;

    logic [SW-1:0] scan_idx;
    logic          num_ok;
    logic          scan_end;
    assign scan_idx = r_scan[SW-1:0];
    assign num_ok   = ({16'd0, r_ev.syscall_number} < 32'(SYSCALL_BINS));
    assign scan_end = (r_scan == TW'(THREAD_SLOTS)) && !r_pv;

    assign o_status.scan_done = scan_end && !r_clr_busy;
    assign o_status.need_bin  = n_need_bin;
    assign o_status.is_clear  = (r_ev.operation == OP_CLEAR) && !r_clr_busy;
    assign o_status.clr_done  = r_clr_busy && (r_clr == CW'(SYSCALL_BINS));
    assign o_result = r_res;

    // scan over slots, one read per cycle, compared in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ev <= i_event;
        end
        if (i_cmd.scan_start) begin
            r_scan       <= '0;
            r_pv         <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_scan != TW'(THREAD_SLOTS)) begin
                r_scan    <= r_scan + 1'b1;
                r_pv      <= 1'b1;
                r_p_idx   <= scan_idx;
                r_p_vld   <= r_valid[scan_idx];
                r_p_thr   <= r_thread[scan_idx];
                r_p_sysc  <= r_sysc[scan_idx];
                r_p_start <= r_start[scan_idx];
            end else begin
                r_pv <= 1'b0;
            end
            if (r_pv) begin
                if (r_p_vld && r_p_thr == r_ev.thread_id && !r_hit) begin
                    r_hit       <= 1'b1;
                    r_hit_idx   <= r_p_idx;
                    r_hit_sysc  <= r_p_sysc;
                    r_hit_start <= r_p_start;
                end
                if (!r_p_vld && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_p_idx;
                end
            end
        end
    end

    // bin request of the current event
    always_comb begin
        n_need_bin = 1'b0;
        n_add_e    = 1'b0;
        n_add_c    = 1'b0;
        n_is_read  = 1'b0;
        unique case (r_ev.operation)
            OP_EXIT: begin
                if (r_hit && r_in_call[r_hit_idx]) begin
                    n_need_bin = 1'b1;
                    n_add_c    = 1'b1;
                    n_add_e    = r_running[r_hit_idx];
                end
            end
            OP_SW_OUT: begin
                if (r_hit && r_in_call[r_hit_idx] && r_running[r_hit_idx]) begin
                    n_need_bin = 1'b1;
                    n_add_e    = 1'b1;
                end
            end
            OP_READ: begin
                if (num_ok) begin
                    n_need_bin = 1'b1;
                    n_is_read  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // slot update and bin request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_in_call  <= '0;
            r_running  <= '0;
        end else if (i_cmd.decide) begin
            r_add_e    <= n_add_e;
            r_add_c    <= n_add_c;
            r_is_read  <= n_is_read;
            r_delta    <= r_ev.energy_reading - r_hit_start;
            r_bin      <= (r_ev.operation == OP_READ) ? r_ev.syscall_number[BW-1:0]
                                                      : r_hit_sysc;
            unique case (r_ev.operation)
                OP_ENTER: begin
                    if (!num_ok) begin
                        if (r_hit) begin
                            r_valid[r_hit_idx]   <= 1'b0;
                            r_in_call[r_hit_idx] <= 1'b0;
                            r_running[r_hit_idx] <= 1'b0;
                        end
                    end else if (r_hit) begin
                        r_sysc[r_hit_idx]    <= r_ev.syscall_number[BW-1:0];
                        r_in_call[r_hit_idx] <= 1'b1;
                        r_running[r_hit_idx] <= 1'b1;
                        r_start[r_hit_idx]   <= r_ev.energy_reading;
                    end else if (r_free_found) begin
                        r_valid[r_free_idx]   <= 1'b1;
                        r_thread[r_free_idx]  <= r_ev.thread_id;
                        r_sysc[r_free_idx]    <= r_ev.syscall_number[BW-1:0];
                        r_in_call[r_free_idx] <= 1'b1;
                        r_running[r_free_idx] <= 1'b1;
                        r_start[r_free_idx]   <= r_ev.energy_reading;
                    end
                end
                OP_EXIT: begin
                    if (r_hit) begin
                        r_valid[r_hit_idx]   <= 1'b0;
                        r_in_call[r_hit_idx] <= 1'b0;
                        r_running[r_hit_idx] <= 1'b0;
                    end
                end
                OP_SW_OUT: begin
                    if (r_hit && r_in_call[r_hit_idx] && r_running[r_hit_idx]) begin
                        r_running[r_hit_idx] <= 1'b0;
                    end
                end
                OP_SW_IN: begin
                    if (r_hit && r_in_call[r_hit_idx] && !r_running[r_hit_idx]) begin
                        r_start[r_hit_idx]   <= r_ev.energy_reading;
                        r_running[r_hit_idx] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // bin memories: registered read, write back, clearing sweep
    logic [64:0] e_sum;
    assign e_sum = {1'b0, r_rd_e} + {33'd0, r_delta};

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_rd) begin
            r_rd_e <= r_ebin[r_bin];
            r_rd_c <= r_cbin[r_bin];
        end
        if (i_cmd.bin_wr && !r_is_read) begin
            if (r_add_e) begin
                r_ebin[r_bin] <= e_sum[64] ? {64{1'b1}} : e_sum[63:0];
            end
            if (r_add_c && r_rd_c != {32{1'b1}}) begin
                r_cbin[r_bin] <= r_rd_c + 32'd1;
            end
        end else if (r_clr_busy && !o_status.clr_done) begin
            r_ebin[r_clr[BW-1:0]] <= '0;
            r_cbin[r_clr[BW-1:0]] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
        end else if (r_clr_busy) begin
            if (o_status.clr_done) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= '0;
        end else if (i_cmd.decide) begin
            r_res.event_dropped <= (r_ev.operation == OP_ENTER) && num_ok
                                   && !r_hit && !r_free_found;
        end else if (i_cmd.out_load && r_is_read) begin
            r_res.bin_energy <= r_rd_e;
            r_res.bin_calls  <= r_rd_c;
        end
    end
endmodule

/* hdl/syscall_energy_attribution_unit.sv */
// top level of the syscall energy attribution unit
// usage:
//   events enter on the i_event channel (operation, thread id, syscall number,
//   energy reading); exactly one result leaves on o_result per event.
//   one event is processed at a time. the thread table is read one slot a
//   cycle and compared in the cycle after; exit, switch out and read add a
//   bin read-modify-write (read, wait, write) when the event needs a bin.
//   clear all sweeps the bin memories one bin a cycle. after reset the same
//   sweep zeroes the bins; events are accepted meanwhile but wait in the
//   scan state behind it.
//   the result is held in a register; while the receiver stalls the result
//   stays valid and no new event is taken.
//   reset clears all thread slots and the bins.
module syscall_energy_attribution_unit #(
    parameter int unsigned SYSCALL_BINS = seau_pkg::SYSCALL_BINS_DEF,
    parameter int unsigned THREAD_SLOTS = seau_pkg::THREAD_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    seau_if.sink   i_event,
    seau_if.source o_result
);
    import seau_pkg::*;

    t_cmd    cmd;
    t_status status;

    seau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_event.valid),
        .o_in_ready  (i_event.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    seau_dp #(
        .SYSCALL_BINS (SYSCALL_BINS),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (i_event.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result.data)
    );
endmodule
